>>> rtl/pcfs_pkg.sv
// ----------------------------------------------------------------------------
// pcfs_pkg: shared types and constants for the pulse-coupled flash sync unit
// Register indexes, configuration and result bundles, value narrowing helper.
// ----------------------------------------------------------------------------
`default_nettype none

package pcfs_pkg;

   // Width of the phase arithmetic; the phase register carries one extra bit.
   localparam int PHASE_BITS = 16;
   localparam int PhaseW     = PHASE_BITS + 1;

   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 16;
   localparam int DrawW    = 16;

   typedef enum logic [CsrIdxW-1:0] {
      REG_ENABLE       = 3'd0,
      REG_MIN_BOOST    = 3'd1,
      REG_MAX_BOOST    = 3'd2,
      REG_CYCLE_LENGTH = 3'd3,
      REG_FLASH_WINDOW = 3'd4
   } reg_idx_type;

   localparam logic [CsrDataW-1:0] RstMinBoost   = 16'd500;
   localparam logic [CsrDataW-1:0] RstMaxBoost   = 16'd1000;
   localparam logic [CsrDataW-1:0] RstCycleLen   = 16'd20000;
   localparam logic [CsrDataW-1:0] RstFlashWin   = 16'd200;

   typedef struct packed {
      logic                enable;
      logic [CsrDataW-1:0] min_boost;
      logic [CsrDataW-1:0] max_boost;
      logic [CsrDataW-1:0] cycle_length;
      logic [CsrDataW-1:0] flash_window;
   } cfg_type;

   typedef struct packed {
      logic flash_led;
      logic send_packet;
      logic cycle_done;
      logic is_synced;
   } res_type;

   // Take a 16-bit field modulo 2^PHASE_BITS (zero-extends when wider).
   function automatic logic [PHASE_BITS-1:0] val_of(input logic [15:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[PHASE_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/pcfs_osc.sv
// ----------------------------------------------------------------------------
// pcfs_osc: oscillator state and single-tick update
// Holds the phase counter and sync bookkeeping; computes one tick's result.
// ----------------------------------------------------------------------------
`default_nettype none

module pcfs_osc
   import pcfs_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire cfg_type          cfg,
   input  wire logic             peer_flash,
   input  wire logic [DrawW-1:0] boost_draw,
   output res_type               res
);

   logic [PhaseW-1:0]     phase_ff, phase_in;
   logic                  flashed_ff, flashed_in;
   logic                  boosted_ff, boosted_in;
   logic                  started_ff, started_in;
   logic [1:0]            quiet_ff, quiet_in;
   logic                  synced_ff, synced_in;

   logic [PHASE_BITS-1:0] len, win, lo, hi, boost, start, half;
   logic [PhaseW-1:0]     len_x, boost_x;
   logic                  led, send, done;

   // boost clamp: raise to min first, then cap at max (max wins)
   always_comb begin
      lo    = val_of(cfg.min_boost);
      hi    = val_of(cfg.max_boost);
      boost = val_of(boost_draw);
      if (boost < lo) begin
         boost = lo;
      end
      if (boost > hi) begin
         boost = hi;
      end
   end

   assign len     = val_of(cfg.cycle_length);
   assign win     = val_of(cfg.flash_window);
   assign len_x   = {1'b0, len};
   assign boost_x = {1'b0, boost};
   assign half    = len >> 1;
   assign start   = (win > len) ? '0 : len - win;

   always_comb begin
      phase_in   = phase_ff;
      flashed_in = flashed_ff;
      boosted_in = boosted_ff;
      started_in = started_ff;
      quiet_in   = quiet_ff;
      synced_in  = synced_ff;
      led        = 1'b0;
      send       = 1'b0;
      done       = 1'b0;
      if (!cfg.enable) begin
         phase_in   = '0;
         flashed_in = 1'b0;
         boosted_in = 1'b0;
      end else begin
         if (phase_ff < len_x) begin
            if (peer_flash) begin
               boosted_in = 1'b1;
               started_in = 1'b1;
               quiet_in   = 2'd0;
               if (phase_ff < {1'b0, half}) begin
                  phase_in = (phase_ff >= boost_x) ? phase_ff - boost_x : '0;
               end else begin
                  phase_in = phase_ff + boost_x;
               end
            end else if (phase_ff >= {1'b0, start}) begin
               led        = 1'b1;
               send       = 1'b1;
               flashed_in = 1'b1;
               phase_in   = len_x;
            end else begin
               phase_in = phase_ff + PhaseW'(1);
            end
         end
         if (phase_in >= len_x) begin
            done = 1'b1;
            if (!boosted_in && started_in && (quiet_in != 2'd3)) begin
               quiet_in = quiet_in + 2'd1;
            end
            if (!flashed_in) begin
               led = 1'b1;  // silent flash at period end
            end
            if (quiet_in == 2'd2) begin
               synced_in = 1'b1;
            end
            phase_in   = '0;
            flashed_in = 1'b0;
            boosted_in = 1'b0;
         end
      end
   end

   assign res.flash_led   = led;
   assign res.send_packet = send;
   assign res.cycle_done  = done;
   assign res.is_synced   = synced_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         flashed_ff <= 1'b0;
         boosted_ff <= 1'b0;
         started_ff <= 1'b0;
         quiet_ff   <= 2'd0;
         synced_ff  <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         flashed_ff <= flashed_in;
         boosted_ff <= boosted_in;
         started_ff <= started_in;
         quiet_ff   <= quiet_in;
         synced_ff  <= synced_in;
      end
   end

   // synced is sticky
   a_synced_sticky: assert property (@(posedge clock) disable iff (reset)
      synced_ff |=> synced_ff)
      else $error("synced flag dropped");

endmodule

`default_nettype wire

>>> rtl/pulse_coupled_flash_sync_unit.sv
// ----------------------------------------------------------------------------
// pulse_coupled_flash_sync_unit: pulse-coupled oscillator flash synchronizer
// One request per tick; adjusts the phase on peer flashes and reports flashes.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake           Payload
//   req_     in         req_valid/req_stall peer_flash, boost_draw[15:0]
//   rsp_     out        rsp_valid/rsp_stall flash_led, send_packet, cycle_done,
//                                           is_synced
//   csr_     in         csr_valid/csr_ready csr_index[2:0], csr_wdata[15:0]
//
// A request lands in the input register, is evaluated combinationally against
// the oscillator state and lands in the result register; one request per cycle
// is sustained while rsp_stall is low. The combinational state update
// (compare, clamp, 17-bit add) sets that rate.
// Reset (synchronous) loads the register defaults and clears the phase.
// A stalled result holds its register; the input register still takes one
// more request, then req_stall rises until the result drains.
//
`default_nettype none

module pulse_coupled_flash_sync_unit
   import pcfs_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // requests
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic                req_peer_flash,
   input  wire logic [DrawW-1:0]    req_boost_draw,
   // results
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic                rsp_flash_led,
   output      logic                rsp_send_packet,
   output      logic                rsp_cycle_done,
   output      logic                rsp_is_synced,
   // register writes
   input  wire logic                csr_valid,
   output      logic                csr_ready,
   input  wire logic [CsrIdxW-1:0]  csr_index,
   input  wire logic [CsrDataW-1:0] csr_wdata
);

   cfg_type          cfg_ff, cfg_in;

   logic             in_valid_ff, in_valid_in;
   logic             in_peer_ff;
   logic [DrawW-1:0] in_draw_ff;

   logic             out_valid_ff, out_valid_in;
   res_type          out_res_ff;
   res_type          step_res;

   logic             req_take;
   logic             advance;

   // ---- configuration registers; writes always accepted ----
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_ENABLE:       cfg_in.enable       = csr_wdata[0];
            REG_MIN_BOOST:    cfg_in.min_boost    = csr_wdata;
            REG_MAX_BOOST:    cfg_in.max_boost    = csr_wdata;
            REG_CYCLE_LENGTH: cfg_in.cycle_length = csr_wdata;
            REG_FLASH_WINDOW: cfg_in.flash_window = csr_wdata;
            default:          cfg_in = cfg_ff;  // unmapped index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable       <= 1'b0;
         cfg_ff.min_boost    <= RstMinBoost;
         cfg_ff.max_boost    <= RstMaxBoost;
         cfg_ff.cycle_length <= RstCycleLen;
         cfg_ff.flash_window <= RstFlashWin;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---- pipeline control ----
   // evaluate when a request waits and the result slot is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_peer_ff <= req_peer_flash;
         in_draw_ff <= req_boost_draw;
      end
      if (advance) begin
         out_res_ff <= step_res;
      end
   end

   // ---- oscillator ----
   pcfs_osc u_osc (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .cfg        (cfg_ff),
      .peer_flash (in_peer_ff),
      .boost_draw (in_draw_ff),
      .res        (step_res)
   );

   assign rsp_valid       = out_valid_ff;
   assign rsp_flash_led   = out_res_ff.flash_led;
   assign rsp_send_packet = out_res_ff.send_packet;
   assign rsp_cycle_done  = out_res_ff.cycle_done;
   assign rsp_is_synced   = out_res_ff.is_synced;

   // ---- checks ----
   a_send_has_led: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_send_packet) |-> rsp_flash_led)
      else $error("send without flash");

   a_send_ends_cycle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_send_packet) |-> rsp_cycle_done)
      else $error("send without cycle end");

   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("evaluated request lost");

endmodule

`default_nettype wire
